>>> design/iopm_pkg.sv
`timescale 1ns / 1ps
package iopm_pkg;
  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_ACC   = 2'd1;
  localparam logic [1:0] KIND_DRAIN = 2'd2;

  localparam logic [2:0] REG_ROWS  = 3'd0;
  localparam logic [2:0] REG_COLS  = 3'd1;
  localparam logic [2:0] REG_SCALE = 3'd2;
  localparam logic [2:0] REG_CLO   = 3'd3;
  localparam logic [2:0] REG_CHI   = 3'd4;

  localparam int LANES = 8;

  // controller -> datapath commands
  typedef struct packed {
    logic       load;      // capture input item
    logic       clr_row;   // zero current row
    logic       acc_row;   // add outer product slice into current row
    logic       rd;        // read accumulator at (row, col)
    logic       rq;        // requantize stage 1 (multiply)
    logic       fin;       // requantize stage 2 (round, clamp) into output reg
    logic [2:0] row;
    logic [2:0] col;
    logic       last;
  } iopm_cmd_t;
endpackage

>>> design/iopm_if.sv
`timescale 1ns / 1ps
interface iopm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] a_column;
  logic [63:0] b_row;
  modport source (output valid, kind, a_column, b_row, input ready);
  modport sink (input valid, kind, a_column, b_row, output ready);
endinterface

interface iopm_out_if;
  logic              valid;
  logic              ready;
  logic [2:0]        out_row;
  logic [2:0]        out_col;
  logic signed [7:0] out_value;
  logic              last;
  modport source (output valid, out_row, out_col, out_value, last, input ready);
  modport sink (input valid, out_row, out_col, out_value, last, output ready);
endinterface

>>> design/iopm_datapath.sv
`timescale 1ns / 1ps
module iopm_datapath #(
  parameter int TILE = 8
) (
  input  logic               clk,
  input  iopm_pkg::iopm_cmd_t cmd,
  input  logic [63:0]        a_column,
  input  logic [63:0]        b_row,
  input  logic [3:0]         cols,
  input  logic [31:0]        scale,
  input  logic signed [7:0]  clamp_low,
  input  logic signed [7:0]  clamp_high,
  output logic [2:0]         out_row,
  output logic [2:0]         out_col,
  output logic signed [7:0]  out_value,
  output logic               out_last
);
  import iopm_pkg::*;

  // one row of the tile per memory word; only lanes 0..7 ever get written
  localparam int AW = (TILE > 1) ? $clog2(TILE) : 1;
  localparam int NL = (TILE < LANES) ? TILE : LANES;
  localparam int CW = (NL > 1) ? $clog2(NL) : 1;

  logic [31:0] mem [TILE][NL];
  logic [63:0] a_q, b_q;
  logic [31:0] rd_q;
  logic        neg1, neg2;
  logic [63:0] prod;
  logic [2:0]  r1, c1, r2, c2;
  logic        l1, l2;
  logic [AW-1:0] ridx;
  logic [CW-1:0] cidx;
  logic signed [7:0] a_s;
  logic [31:0] mag;
  logic [47:0] q;
  logic signed [49:0] v;

  assign ridx = AW'(cmd.row);
  assign cidx = CW'(cmd.col);
  assign a_s  = a_q[8*cmd.row +: 8];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_q <= a_column;
      b_q <= b_row;
    end
    for (int c = 0; c < NL; c++) begin
      if (cmd.clr_row) begin
        mem[ridx][c] <= '0;
      end else if (cmd.acc_row && (4'(c) < cols)) begin
        mem[ridx][c] <= mem[ridx][c] +
          (32'(a_s) * 32'($signed(b_q[8*c +: 8])));
      end
    end
    if (cmd.rd) begin
      rd_q <= mem[ridx][cidx];
      r1 <= cmd.row; c1 <= cmd.col; l1 <= cmd.last;
    end
    if (cmd.rq) begin
      neg1 <= rd_q[31];
      prod <= 64'(mag) * 64'(scale);
      r2 <= r1; c2 <= c1; l2 <= l1;
    end
    if (cmd.fin) begin
      out_row <= r2; out_col <= c2; out_last <= l2;
      // minimum first, then maximum: crossed bounds always give clamp_high
      if (v < 50'(clamp_low))
        out_value <= (clamp_low > clamp_high) ? clamp_high : clamp_low;
      else if (v > 50'(clamp_high)) out_value <= clamp_high;
      else out_value <= v[7:0];
    end
  end

  assign mag  = rd_q[31] ? (32'd0 - rd_q) : rd_q;
  assign q    = 48'((prod + 64'h8000) >> 16);
  assign neg2 = neg1;
  assign v    = neg2 ? -$signed({2'b00, q}) : $signed({2'b00, q});
endmodule

>>> design/iopm_ctrl.sv
`timescale 1ns / 1ps
module iopm_ctrl #(
  parameter int TILE = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [1:0]         kind,
  output logic               in_ready,
  input  logic [3:0]         rows,
  input  logic [3:0]         cols,
  output iopm_pkg::iopm_cmd_t cmd,
  output logic               out_valid,
  input  logic               out_ready
);
  import iopm_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CLR  = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam int TR = (TILE < 8) ? TILE : 8;

  logic [2:0] state, state_next;
  logic [3:0] r, c, r_next, c_next;
  logic [3:0] rows_a, cols_a;
  logic       ov, ov_next;

  assign rows_a = (rows > 4'(TR)) ? 4'(TR) : rows;
  assign cols_a = (cols > 4'(TR)) ? 4'(TR) : cols;
  assign in_ready = (state == S_IDLE);
  assign out_valid = ov;

  always_comb begin
    state_next = state; r_next = r; c_next = c; ov_next = ov;
    cmd = '0;
    cmd.row = r[2:0]; cmd.col = c[2:0];
    cmd.last = (r + 4'd1 == rows_a) && (c + 4'd1 == cols_a);
    if (ov && out_ready) ov_next = 1'b0;
    unique case (state)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1; r_next = '0; c_next = '0;
        if (kind == KIND_CLEAR) state_next = S_CLR;
        else if (kind == KIND_ACC && rows_a != 0 && cols_a != 0) state_next = S_ACC;
        else if (kind == KIND_DRAIN && rows_a != 0 && cols_a != 0) state_next = S_RD;
      end
      S_CLR: begin
        cmd.clr_row = 1'b1; r_next = r + 4'd1;
        if (r + 4'd1 >= 4'(TR)) state_next = S_IDLE;
      end
      S_ACC: begin
        cmd.acc_row = 1'b1; r_next = r + 4'd1;
        if (r + 4'd1 >= rows_a) state_next = S_IDLE;
      end
      S_RD: begin cmd.rd = 1'b1; state_next = S_MUL; end
      S_MUL: begin cmd.rq = 1'b1; state_next = S_FIN; end
      S_FIN: if (!ov || out_ready) begin
        cmd.fin = 1'b1; ov_next = 1'b1;
        if (c + 4'd1 < cols_a) begin c_next = c + 4'd1; state_next = S_RD; end
        else if (r + 4'd1 < rows_a) begin
          c_next = '0; r_next = r + 4'd1; state_next = S_RD;
        end else state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR; r <= '0; c <= '0; ov <= 1'b0;
    end else begin
      state <= state_next; r <= r_next; c <= c_next; ov <= ov_next;
    end
  end
endmodule

>>> design/int8_outer_product_matmul_requant.sv
`timescale 1ns / 1ps
// Clear: after accept, TILE rows (capped at 8) are cleared, one per cycle.
// Accumulate: after accept, one accumulator row per cycle (rows_a, rows capped at 8).
// Drain: each element is read, multiplied, then rounded/clamped; the last step
// waits while the output holds an untaken result. One item at a time.
// Reset (rst, synchronous): registers to defaults, then a row clearing pass.
module int8_outer_product_matmul_requant #(
  parameter int TILE = 8
) (
  input  logic        clk,
  input  logic        rst,
  iopm_in_if.sink     in_ch,
  iopm_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import iopm_pkg::*;

  logic [3:0]  rows, cols;
  logic [31:0] scale;
  logic signed [7:0] clamp_low, clamp_high;
  iopm_cmd_t cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows <= 4'd8; cols <= 4'd8; scale <= 32'h10000;
      clamp_low <= -8'sd128; clamp_high <= 8'sd127;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROWS:  rows <= cfg_data[3:0];
        REG_COLS:  cols <= cfg_data[3:0];
        REG_SCALE: scale <= cfg_data;
        REG_CLO:   clamp_low <= cfg_data[7:0];
        REG_CHI:   clamp_high <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  iopm_ctrl #(.TILE(TILE)) u_ctrl (
    .clk, .rst, .in_valid(in_ch.valid), .kind(in_ch.kind), .in_ready(in_ch.ready),
    .rows, .cols, .cmd, .out_valid(out_ch.valid), .out_ready(out_ch.ready)
  );

  iopm_datapath #(.TILE(TILE)) u_dp (
    .clk, .cmd, .a_column(in_ch.a_column), .b_row(in_ch.b_row), .cols, .scale,
    .clamp_low, .clamp_high, .out_row(out_ch.out_row), .out_col(out_ch.out_col),
    .out_value(out_ch.out_value), .out_last(out_ch.last)
  );

  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $countones({cmd.clr_row, cmd.acc_row, cmd.rd, cmd.fin}) <= 1) else $error("cmd overlap");
  a_fin_free: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |-> (!out_ch.valid || out_ch.ready)) else $error("output overwrite");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.rd || cmd.acc_row) |-> !in_ch.ready) else $error("ready while busy");
endmodule
